/* hw/rtl/ofd_pkg.sv */
// Shared types and constants for the orthonormal frame pipeline.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package ofd_pkg;

  // Field widths fixed by the interface.
  localparam int DIR_W  = 16;
  localparam int AXIS_W = 16;

  // Raw X components stay within +/- 2^31, so 33 signed bits hold them.
  localparam int RAW_W  = 33;
  // Magnitudes of raw components and of the aligned vector.
  localparam int MAG_W  = 32;
  // Shift amount that brings the largest magnitude up to bit 30.
  localparam int SH_W   = 5;
  // Sum of three squared aligned magnitudes.
  localparam int SQ_W   = 64;
  // Bit pairs resolved by the square root, one per stage.
  localparam int ROOT_STEPS = 32;

  // Branch test: 1000000 * z^2 > 332929 * |d|^2.
  localparam int SUM_W = 32;
  localparam int CMP_W = 51;
  localparam logic [19:0] BR_NUM = 20'd1000000;
  localparam logic [18:0] BR_DEN = 19'd332929;

  // Two normalising lanes: the direction and the raw X axis.
  localparam int NORM_LANES = 2;
  localparam int LANE_Z = 0;
  localparam int LANE_X = 1;

  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7fff;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;

  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [RAW_W-1:0]  raw_t;

  // Side band that travels alongside each request through the stages.
  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/ofd_in_if.sv */
// Request channel carrying one direction vector.
// Depends on ofd_pkg for the field type.
`default_nettype none

interface ofd_in_if import ofd_pkg::*; ();
  logic valid;
  logic ready;
  dir_t dir_x;
  dir_t dir_y;
  dir_t dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ofd_out_if.sv */
// Result channel carrying one orthonormal frame and the degenerate flag.
// Depends on ofd_pkg for the field type.
`default_nettype none

interface ofd_out_if import ofd_pkg::*; ();
  logic  valid;
  logic  ready;
  axis_t xaxis_x;
  axis_t xaxis_y;
  axis_t xaxis_z;
  axis_t yaxis_x;
  axis_t yaxis_y;
  axis_t yaxis_z;
  axis_t zaxis_x;
  axis_t zaxis_y;
  axis_t zaxis_z;
  logic  degenerate;

  modport source (output valid, output xaxis_x, output xaxis_y, output xaxis_z,
                  output yaxis_x, output yaxis_y, output yaxis_z,
                  output zaxis_x, output zaxis_y, output zaxis_z,
                  output degenerate, input ready);
  modport sink (input valid, input xaxis_x, input xaxis_y, input xaxis_z,
                input yaxis_x, input yaxis_y, input yaxis_z,
                input zaxis_x, input zaxis_y, input zaxis_z,
                input degenerate, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ofd_prep.sv */
// Front stages: products of the direction components, branch test and raw X axis.
// Depends on ofd_pkg. Three register stages, all advanced by en.
`default_nettype none

module ofd_prep import ofd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_in,
  input  dir_t dir_in [3],
  output ctl_t ctl_out,
  output raw_t d_out [3],
  output raw_t xr_out [3]
);

  // Stage 1 registers: component products.
  ctl_t               c1_r;
  dir_t               d1_r [3];
  logic [30:0]        xx1_r, yy1_r, zz1_r;
  logic signed [31:0] xz1_r, yz1_r;

  // Stage 2 registers: branch products and both candidate X vectors.
  ctl_t             c2_r;
  dir_t             d2_r [3];
  logic [CMP_W-1:0] lhs2_r, rhs2_r;
  raw_t             ax2_r, bx2_r, y2_r, az2_r, bz2_r;

  // Stage 3 registers: selected X and aligned direction.
  ctl_t c3_r;
  raw_t d3_r [3];
  raw_t xr3_r [3];

  logic signed [31:0] xx_c, yy_c, zz_c, xz_c, yz_c;
  logic [SUM_W-1:0]   s_c;

  // Squares and cross products of the inputs.
  always_comb begin
    xx_c = dir_in[0] * dir_in[0];
    yy_c = dir_in[1] * dir_in[1];
    zz_c = dir_in[2] * dir_in[2];
    xz_c = dir_in[0] * dir_in[2];
    yz_c = dir_in[1] * dir_in[2];
  end

  // Squared length of the direction.
  assign s_c = SUM_W'(xx1_r) + SUM_W'(yy1_r) + SUM_W'(zz1_r);

  // Valid and degenerate flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r.valid <= vld_in;
      c1_r.degen <= (dir_in[0] == '0) && (dir_in[1] == '0) && (dir_in[2] == '0);
      c2_r       <= c1_r;
      c3_r       <= c2_r;
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= dir_in;
      xx1_r <= xx_c[30:0];
      yy1_r <= yy_c[30:0];
      zz1_r <= zz_c[30:0];
      xz1_r <= xz_c;
      yz1_r <= yz_c;

      d2_r   <= d1_r;
      lhs2_r <= CMP_W'(zz1_r) * CMP_W'(BR_NUM);
      rhs2_r <= CMP_W'(s_c) * CMP_W'(BR_DEN);
      ax2_r  <= -raw_t'({2'b00, zz1_r});
      bx2_r  <= -raw_t'(xz1_r);
      y2_r   <= -raw_t'(yz1_r);
      az2_r  <= raw_t'(xz1_r) + raw_t'({2'b00, yy1_r});
      bz2_r  <= raw_t'({2'b00, xx1_r}) + raw_t'({2'b00, yy1_r});

      for (int c = 0; c < 3; c++) begin
        d3_r[c] <= raw_t'(d2_r[c]);
      end
      // A steep direction uses the first formula, otherwise the second.
      if (lhs2_r > rhs2_r) begin
        xr3_r[0] <= ax2_r;
        xr3_r[2] <= az2_r;
      end else begin
        xr3_r[0] <= bx2_r;
        xr3_r[2] <= bz2_r;
      end
      xr3_r[1] <= y2_r;
    end
  end

  assign ctl_out = c3_r;
  assign d_out   = d3_r;
  assign xr_out  = xr3_r;

endmodule

`default_nettype wire

/* hw/rtl/ofd_norm.sv */
// Normalises two 3-vectors side by side: alignment, squares, a bit-pair square root
// and a one-bit-per-stage restoring division. Depends on ofd_pkg.
`default_nettype none

module ofd_norm import ofd_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  ctl_t ctl_in,
  input  raw_t v_in [NORM_LANES][3],
  output ctl_t ctl_out,
  output logic signed [FRAC_BITS+1:0] q_out [NORM_LANES][3]
);

  localparam int QW  = FRAC_BITS + 1;
  localparam int OW  = FRAC_BITS + 2;
  localparam int DW  = MAG_W + 1;
  localparam int NW  = MAG_W + FRAC_BITS + 2;
  localparam int NST = ROOT_STEPS + QW + 7;

  function automatic logic [MAG_W-1:0] abs_mag(input raw_t v);
    raw_t a;
    a = v[RAW_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // Side band follows the data stage for stage.
  ctl_t ctl_r [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < NST; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign ctl_out = ctl_r[NST-1];

  // Stages 1 to 4: magnitudes, alignment shift, aligned values, squares.
  logic [MAG_W-1:0] u1_r  [NORM_LANES][3];
  logic             sg1_r [NORM_LANES][3];
  logic [MAG_W-1:0] u2_r  [NORM_LANES][3];
  logic             sg2_r [NORM_LANES][3];
  logic [SH_W-1:0]  sh2_r [NORM_LANES];
  logic             nz2_r [NORM_LANES];
  logic [MAG_W-1:0] us3_r [NORM_LANES][3];
  logic             sg3_r [NORM_LANES][3];
  logic             nz3_r [NORM_LANES];
  logic [SQ_W-1:0]  sq4_r [NORM_LANES][3];
  logic [MAG_W-1:0] us4_r [NORM_LANES][3];
  logic             sg4_r [NORM_LANES][3];
  logic             nz4_r [NORM_LANES];

  logic [MAG_W-1:0] orv_c [NORM_LANES];
  logic [SH_W-1:0]  sh_c  [NORM_LANES];

  // The top set bit of the OR of the magnitudes is that of the largest one.
  always_comb begin
    for (int l = 0; l < NORM_LANES; l++) begin
      orv_c[l] = u1_r[l][0] | u1_r[l][1] | u1_r[l][2];
      sh_c[l]  = '0;
      for (int i = 0; i < MAG_W; i++) begin
        if (orv_c[l][i]) begin
          sh_c[l] = (i >= MAG_W - 2) ? '0 : SH_W'(MAG_W - 2 - i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NORM_LANES; l++) begin
        for (int c = 0; c < 3; c++) begin
          sg1_r[l][c] <= v_in[l][c][RAW_W-1];
          u1_r[l][c]  <= abs_mag(v_in[l][c]);
          u2_r[l][c]  <= u1_r[l][c];
          sg2_r[l][c] <= sg1_r[l][c];
          us3_r[l][c] <= u2_r[l][c] << sh2_r[l];
          sg3_r[l][c] <= sg2_r[l][c];
          sq4_r[l][c] <= SQ_W'(us3_r[l][c]) * SQ_W'(us3_r[l][c]);
          us4_r[l][c] <= us3_r[l][c];
          sg4_r[l][c] <= sg3_r[l][c];
        end
        sh2_r[l] <= sh_c[l];
        nz2_r[l] <= |orv_c[l];
        nz3_r[l] <= nz2_r[l];
        nz4_r[l] <= nz3_r[l];
      end
    end
  end

  // Square root: entry 0 holds the sum, each later entry resolves one bit pair.
  logic [SQ_W-1:0]  rn_r  [ROOT_STEPS+1][NORM_LANES];
  logic [SQ_W-1:0]  rr_r  [ROOT_STEPS+1][NORM_LANES];
  logic [MAG_W-1:0] rus_r [ROOT_STEPS+1][NORM_LANES][3];
  logic             rsg_r [ROOT_STEPS+1][NORM_LANES][3];
  logic             rnz_r [ROOT_STEPS+1][NORM_LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NORM_LANES; l++) begin
        rn_r[0][l]  <= sq4_r[l][0] + sq4_r[l][1] + sq4_r[l][2];
        rr_r[0][l]  <= '0;
        rus_r[0][l] <= us4_r[l];
        rsg_r[0][l] <= sg4_r[l];
        rnz_r[0][l] <= nz4_r[l];
      end
    end
  end

  for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
    localparam logic [SQ_W-1:0] RB = SQ_W'(1) << (SQ_W - 2 * j);
    logic [SQ_W:0] tr_c [NORM_LANES];

    always_comb begin
      for (int l = 0; l < NORM_LANES; l++) begin
        tr_c[l] = {1'b0, rr_r[j-1][l]} + {1'b0, RB};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NORM_LANES; l++) begin
          if ({1'b0, rn_r[j-1][l]} >= tr_c[l]) begin
            rn_r[j][l] <= rn_r[j-1][l] - tr_c[l][SQ_W-1:0];
            rr_r[j][l] <= (rr_r[j-1][l] >> 1) + RB;
          end else begin
            rn_r[j][l] <= rn_r[j-1][l];
            rr_r[j][l] <= rr_r[j-1][l] >> 1;
          end
          rus_r[j][l] <= rus_r[j-1][l];
          rsg_r[j][l] <= rsg_r[j-1][l];
          rnz_r[j][l] <= rnz_r[j-1][l];
        end
      end
    end
  end

  // Division: entry 0 holds the rounded numerator, then one quotient bit per stage.
  logic [NW-1:0] dr_r  [QW+1][NORM_LANES][3];
  logic [QW-1:0] dq_r  [QW+1][NORM_LANES][3];
  logic [DW-1:0] dd_r  [QW+1][NORM_LANES];
  logic          dsg_r [QW+1][NORM_LANES][3];
  logic          dnz_r [QW+1][NORM_LANES];

  logic [MAG_W-1:0] m_c [NORM_LANES];

  always_comb begin
    for (int l = 0; l < NORM_LANES; l++) begin
      m_c[l] = rr_r[ROOT_STEPS][l][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NORM_LANES; l++) begin
        for (int c = 0; c < 3; c++) begin
          dr_r[0][l][c] <= (NW'(rus_r[ROOT_STEPS][l][c]) << QW) + NW'(m_c[l]);
          dq_r[0][l][c] <= '0;
        end
        dd_r[0][l]  <= {m_c[l], 1'b0};
        dsg_r[0][l] <= rsg_r[ROOT_STEPS][l];
        dnz_r[0][l] <= rnz_r[ROOT_STEPS][l];
      end
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_div
    localparam int K = QW - i;
    logic [NW-1:0] tv_c [NORM_LANES];

    always_comb begin
      for (int l = 0; l < NORM_LANES; l++) begin
        tv_c[l] = NW'(dd_r[i-1][l]) << K;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NORM_LANES; l++) begin
          for (int c = 0; c < 3; c++) begin
            if (dr_r[i-1][l][c] >= tv_c[l]) begin
              dr_r[i][l][c] <= dr_r[i-1][l][c] - tv_c[l];
              dq_r[i][l][c] <= dq_r[i-1][l][c] | (QW'(1) << K);
            end else begin
              dr_r[i][l][c] <= dr_r[i-1][l][c];
              dq_r[i][l][c] <= dq_r[i-1][l][c];
            end
          end
          dd_r[i][l]  <= dd_r[i-1][l];
          dsg_r[i][l] <= dsg_r[i-1][l];
          dnz_r[i][l] <= dnz_r[i-1][l];
        end
      end
    end
  end

  // Restore the signs; an all-zero vector normalises to zero.
  logic signed [OW-1:0] q_r [NORM_LANES][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NORM_LANES; l++) begin
        for (int c = 0; c < 3; c++) begin
          if (!dnz_r[QW][l]) begin
            q_r[l][c] <= '0;
          end else if (dsg_r[QW][l][c]) begin
            q_r[l][c] <= -$signed({1'b0, dq_r[QW][l][c]});
          end else begin
            q_r[l][c] <= $signed({1'b0, dq_r[QW][l][c]});
          end
        end
      end
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

/* hw/rtl/ofd_cross.sv */
// Y axis as the cross product Z x X, rounded and clamped, plus saturation of
// all nine axis values to the field range. Depends on ofd_pkg.
`default_nettype none

module ofd_cross import ofd_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_in,
  input  logic signed [FRAC_BITS+1:0] zq_in [3],
  input  logic signed [FRAC_BITS+1:0] xq_in [3],
  output ctl_t  ctl_out,
  output axis_t xa_out [3],
  output axis_t ya_out [3],
  output axis_t za_out [3]
);

  localparam int OW  = FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int PW  = 2 * OW;
  localparam int DFW = PW + 1;
  localparam int WW  = OW + AXIS_W;
  localparam logic [DFW:0] HALF = (DFW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [DFW:0] ONE  = (DFW + 1)'(1) << FRAC_BITS;

  function automatic axis_t sat_axis(input logic signed [OW-1:0] v);
    logic signed [WW-1:0] w;
    w = WW'(v);
    if (w > WW'(AXIS_MAX)) begin
      return AXIS_MAX;
    end else if (w < WW'(AXIS_MIN)) begin
      return AXIS_MIN;
    end
    return w[AXIS_W-1:0];
  endfunction

  ctl_t                  c1_r, c2_r, c3_r;
  logic signed [PW-1:0]  pa1_r [3];
  logic signed [PW-1:0]  pb1_r [3];
  logic signed [OW-1:0]  z1_r [3];
  logic signed [OW-1:0]  x1_r [3];
  logic signed [DFW-1:0] df2_r [3];
  logic signed [OW-1:0]  z2_r [3];
  logic signed [OW-1:0]  x2_r [3];
  axis_t                 xa3_r [3];
  axis_t                 ya3_r [3];
  axis_t                 za3_r [3];

  logic signed [PW-1:0]  pa_c [3];
  logic signed [PW-1:0]  pb_c [3];
  logic [DFW-1:0]        mg_c [3];
  logic [DFW:0]          rq_c [3];
  logic [QW-1:0]         rc_c [3];
  logic signed [OW-1:0]  yv_c [3];

  // Pairs of products for each Y component.
  always_comb begin
    pa_c[0] = zq_in[1] * xq_in[2];
    pb_c[0] = zq_in[2] * xq_in[1];
    pa_c[1] = zq_in[2] * xq_in[0];
    pb_c[1] = zq_in[0] * xq_in[2];
    pa_c[2] = zq_in[0] * xq_in[1];
    pb_c[2] = zq_in[1] * xq_in[0];
  end

  // Round half away from zero, then clamp the magnitude to 1.0.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mg_c[c] = df2_r[c][DFW-1] ? DFW'(-df2_r[c]) : DFW'(df2_r[c]);
      rq_c[c] = ({1'b0, mg_c[c]} + HALF) >> FRAC_BITS;
      rc_c[c] = (rq_c[c] > ONE) ? ONE[QW-1:0] : rq_c[c][QW-1:0];
      yv_c[c] = df2_r[c][DFW-1] ? -$signed({1'b0, rc_c[c]}) : $signed({1'b0, rc_c[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= ctl_in;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pa1_r[c] <= pa_c[c];
        pb1_r[c] <= pb_c[c];
        z1_r[c]  <= zq_in[c];
        x1_r[c]  <= xq_in[c];
        df2_r[c] <= DFW'(pa1_r[c]) - DFW'(pb1_r[c]);
        z2_r[c]  <= z1_r[c];
        x2_r[c]  <= x1_r[c];
        xa3_r[c] <= sat_axis(x2_r[c]);
        ya3_r[c] <= sat_axis(yv_c[c]);
        za3_r[c] <= sat_axis(z2_r[c]);
      end
    end
  end

  assign ctl_out = c3_r;
  assign xa_out  = xa3_r;
  assign ya_out  = ya3_r;
  assign za_out  = za3_r;

endmodule

`default_nettype wire

/* hw/rtl/orthonormal_frame_from_direction.sv */
// Orthonormal frame from a direction vector: top level with pipeline control.
// Depends on ofd_pkg, ofd_in_if, ofd_out_if, ofd_prep, ofd_norm and ofd_cross.
//
//   Channel  Port    Direction  Contents
//   request  in_ch   sink       dir_x, dir_y, dir_z (signed integers)
//   result   out_ch  source     xaxis_*, yaxis_*, zaxis_* (Q1.FRAC_BITS), degenerate
//
// One request is taken per cycle while in_ch.ready is high; each request gives one result.
// Most of the latency is in the 32-stage square root and the FRAC_BITS + 1 stage divider.
// rst_n is synchronous and clears every valid bit; payload registers are not reset.
// The pipeline stops only when its last stage holds a result and the output register
// is full and not being taken; all stages then stop together, so bubbles do not close up.
`default_nettype none

module orthonormal_frame_from_direction import ofd_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input logic      clk,
  input logic      rst_n,
  ofd_in_if.sink   in_ch,
  ofd_out_if.source out_ch
);

  logic pipe_en;
  logic out_valid_r;

  ctl_t pr_ctl, nm_ctl, cx_ctl;
  dir_t pr_dir [3];
  raw_t pr_d [3];
  raw_t pr_xr [3];
  raw_t nm_v [NORM_LANES][3];
  logic signed [FRAC_BITS+1:0] nm_q [NORM_LANES][3];
  axis_t cx_xa [3];
  axis_t cx_ya [3];
  axis_t cx_za [3];

  axis_t xaxis_r [3];
  axis_t yaxis_r [3];
  axis_t zaxis_r [3];
  logic  degen_r;

  // Advance while the last stage is empty or its result has somewhere to go.
  assign pipe_en     = !cx_ctl.valid || !out_valid_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  assign pr_dir[0] = in_ch.dir_x;
  assign pr_dir[1] = in_ch.dir_y;
  assign pr_dir[2] = in_ch.dir_z;

  ofd_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .vld_in  (in_ch.valid),
    .dir_in  (pr_dir),
    .ctl_out (pr_ctl),
    .d_out   (pr_d),
    .xr_out  (pr_xr)
  );

  assign nm_v[LANE_Z] = pr_d;
  assign nm_v[LANE_X] = pr_xr;

  ofd_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .ctl_in  (pr_ctl),
    .v_in    (nm_v),
    .ctl_out (nm_ctl),
    .q_out   (nm_q)
  );

  ofd_cross #(.FRAC_BITS(FRAC_BITS)) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .ctl_in  (nm_ctl),
    .zq_in   (nm_q[LANE_Z]),
    .xq_in   (nm_q[LANE_X]),
    .ctl_out (cx_ctl),
    .xa_out  (cx_xa),
    .ya_out  (cx_ya),
    .za_out  (cx_za)
  );

  // Output register: loads whenever it is free or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      out_valid_r <= cx_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_valid_r) begin
      xaxis_r <= cx_xa;
      yaxis_r <= cx_ya;
      zaxis_r <= cx_za;
      degen_r <= cx_ctl.degen;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.xaxis_x    = xaxis_r[0];
  assign out_ch.xaxis_y    = xaxis_r[1];
  assign out_ch.xaxis_z    = xaxis_r[2];
  assign out_ch.yaxis_x    = yaxis_r[0];
  assign out_ch.yaxis_y    = yaxis_r[1];
  assign out_ch.yaxis_z    = yaxis_r[2];
  assign out_ch.zaxis_x    = zaxis_r[0];
  assign out_ch.zaxis_y    = zaxis_r[1];
  assign out_ch.zaxis_z    = zaxis_r[2];
  assign out_ch.degenerate = degen_r;

endmodule

`default_nettype wire
